// File: hw/rtl/tssg_pkg.sv
// ----------------------------------------------------------------------------
// tssg_pkg
// Shared types, widths and helper functions of the triangle span generator.
// ----------------------------------------------------------------------------
package tssg_pkg;

   localparam int CRD_W   = 16;   // vertex coordinate width
   localparam int ROW_W   = 10;
   localparam int X_W     = 10;
   localparam int COLOR_W = 32;
   localparam int CSR_W   = 32;
   localparam int IDX_W   = 3;

   localparam int DEF_SCREEN_WIDTH  = 1024;
   localparam int DEF_SCREEN_HEIGHT = 1024;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_V0_X  = 3'd0;
   localparam logic [IDX_W-1:0] CSR_V0_Y  = 3'd1;
   localparam logic [IDX_W-1:0] CSR_V1_X  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_V1_Y  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_V2_X  = 3'd4;
   localparam logic [IDX_W-1:0] CSR_V2_Y  = 3'd5;
   localparam logic [IDX_W-1:0] CSR_COLOR = 3'd6;

   // divider: quotient never exceeds the edge's x extent
   localparam int Q_W        = 16;
   localparam int MAG_W      = 2 * CRD_W;      // |dy_row| * |dx|
   localparam int REM_W      = MAG_W + 2;      // 2*mag + den
   localparam int DVS_W      = CRD_W + 1;      // 2*den
   localparam int BITS_STAGE = 2;
   localparam int DIV_STAGES = Q_W / BITS_STAGE;
   localparam int XS_W       = CRD_W + 2;      // interpolated x, signed

   typedef struct packed {
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
   } vtx_type;

   // edge setup values
   typedef struct packed {
      logic signed [CRD_W-1:0] ax;
      logic signed [CRD_W-1:0] bx;
      logic                    neg;
      logic                    flat;
      logic [CRD_W-1:0]        mag_dx;
      logic [CRD_W-1:0]        dyr;
      logic [CRD_W-1:0]        den;
   } edge_type;

   // one lane of the divider pipeline
   typedef struct packed {
      logic signed [CRD_W-1:0] ax;
      logic signed [CRD_W-1:0] bx;
      logic                    neg;
      logic                    flat;
      logic [REM_W-1:0]        rem;
      logic [DVS_W-1:0]        dvs;
      logic [Q_W-1:0]          quo;
   } lane_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic             in_tri;
   } meta_type;

   function automatic edge_type make_edge(vtx_type a, vtx_type b, logic [ROW_W-1:0] r);
      edge_type          e;
      logic signed [CRD_W:0] dx;
      logic signed [CRD_W:0] dyr;
      logic signed [CRD_W:0] den;
      dx  = $signed({b.x[CRD_W-1], b.x}) - $signed({a.x[CRD_W-1], a.x});
      dyr = $signed({{(CRD_W+1-ROW_W){1'b0}}, r}) - $signed({a.y[CRD_W-1], a.y});
      den = $signed({b.y[CRD_W-1], b.y}) - $signed({a.y[CRD_W-1], a.y});
      e.ax     = a.x;
      e.bx     = b.x;
      e.neg    = dx[CRD_W];
      e.mag_dx = dx[CRD_W] ? CRD_W'(-dx) : dx[CRD_W-1:0];
      e.dyr    = dyr[CRD_W-1:0];
      e.den    = den[CRD_W-1:0];
      e.flat   = den[CRD_W] || (den == '0);
      return e;
   endfunction

   // one restoring step producing quotient bit i
   function automatic lane_type div_step(lane_type l, int i);
      lane_type         o;
      logic [REM_W-1:0] trial;
      o     = l;
      trial = REM_W'({l.dvs, {Q_W{1'b0}}} >> (Q_W - i));
      if (l.rem >= trial) begin
         o.rem    = l.rem - trial;
         o.quo[i] = 1'b1;
      end
      return o;
   endfunction

endpackage

// File: hw/rtl/tssg_setup.sv
// ----------------------------------------------------------------------------
// tssg_setup
// Vertex sort, edge setup, multiply and dividend forming (three stages).
// ----------------------------------------------------------------------------
module tssg_setup #(
   parameter int SCREEN_HEIGHT = tssg_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [tssg_pkg::ROW_W-1:0]   row,
   input  tssg_pkg::vtx_type            v0,
   input  tssg_pkg::vtx_type            v1,
   input  tssg_pkg::vtx_type            v2,
   output logic                         out_valid,
   output tssg_pkg::meta_type           out_meta,
   output tssg_pkg::lane_type           out_long,
   output tssg_pkg::lane_type           out_short
);
   import tssg_pkg::*;

   typedef struct packed {
      logic signed [CRD_W-1:0] ax;
      logic signed [CRD_W-1:0] bx;
      logic                    neg;
      logic                    flat;
      logic [MAG_W-1:0]        mag;
      logic [CRD_W-1:0]        den;
   } prod_type;

   vtx_type  p0, p1, p2, t;
   logic     in_tri;
   logic     upper;

   logic     s1_valid_ff, s2_valid_ff, s3_valid_ff;
   meta_type s1_meta_ff, s2_meta_ff, s3_meta_ff;
   edge_type s1_long_ff, s1_short_ff;
   edge_type s1_long_in, s1_short_in;
   prod_type s2_long_ff, s2_short_ff;
   lane_type s3_long_ff, s3_short_ff;

   always_comb begin
      p0 = v0;
      p1 = v1;
      p2 = v2;
      t  = p0;
      if ($signed(p0.y) > $signed(p1.y)) begin
         t = p0; p0 = p1; p1 = t;
      end
      if ($signed(p1.y) > $signed(p2.y)) begin
         t = p1; p1 = p2; p2 = t;
      end
      if ($signed(p0.y) > $signed(p1.y)) begin
         t = p0; p0 = p1; p1 = t;
      end
      in_tri = (int'(row) < SCREEN_HEIGHT)
            && ($signed({1'b0, {(CRD_W-ROW_W){1'b0}}, row}) >= $signed({p0.y[CRD_W-1], p0.y}))
            && ($signed({1'b0, {(CRD_W-ROW_W){1'b0}}, row}) <= $signed({p2.y[CRD_W-1], p2.y}));
      upper  = $signed({1'b0, {(CRD_W-ROW_W){1'b0}}, row}) <= $signed({p1.y[CRD_W-1], p1.y});
      s1_long_in  = make_edge(p0, p2, row);
      s1_short_in = upper ? make_edge(p0, p1, row) : make_edge(p1, p2, row);
   end

   function automatic prod_type mul_edge(edge_type e);
      prod_type p;
      p.ax   = e.ax;
      p.bx   = e.bx;
      p.neg  = e.neg;
      p.flat = e.flat;
      p.mag  = e.dyr * e.mag_dx;
      p.den  = e.den;
      return p;
   endfunction

   function automatic lane_type form_div(prod_type p);
      lane_type l;
      l.ax   = p.ax;
      l.bx   = p.bx;
      l.neg  = p.neg;
      l.flat = p.flat;
      l.rem  = {1'b0, p.mag, 1'b0} + REM_W'(p.den);
      l.dvs  = {p.den, 1'b0};
      l.quo  = '0;
      return l;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_meta_ff  <= '{row: row, in_tri: in_tri};
         s1_long_ff  <= s1_long_in;
         s1_short_ff <= s1_short_in;
         s2_meta_ff  <= s1_meta_ff;
         s2_long_ff  <= mul_edge(s1_long_ff);
         s2_short_ff <= mul_edge(s1_short_ff);
         s3_meta_ff  <= s2_meta_ff;
         s3_long_ff  <= form_div(s2_long_ff);
         s3_short_ff <= form_div(s2_short_ff);
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_meta  = s3_meta_ff;
   assign out_long  = s3_long_ff;
   assign out_short = s3_short_ff;

endmodule

// File: hw/rtl/tssg_div.sv
// ----------------------------------------------------------------------------
// tssg_div
// Two-lane pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module tssg_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  tssg_pkg::meta_type    in_meta,
   input  tssg_pkg::lane_type    in_long,
   input  tssg_pkg::lane_type    in_short,
   output logic                  out_valid,
   output tssg_pkg::meta_type    out_meta,
   output tssg_pkg::lane_type    out_long,
   output tssg_pkg::lane_type    out_short
);
   import tssg_pkg::*;

   logic     valid_ff [DIV_STAGES];
   meta_type meta_ff  [DIV_STAGES];
   lane_type long_ff  [DIV_STAGES];
   lane_type short_ff [DIV_STAGES];
   lane_type long_in  [DIV_STAGES];
   lane_type short_in [DIV_STAGES];

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         long_in[s]  = (s == 0) ? in_long  : long_ff[(s == 0) ? 0 : s-1];
         short_in[s] = (s == 0) ? in_short : short_ff[(s == 0) ? 0 : s-1];
         for (int k = 0; k < BITS_STAGE; k++) begin
            long_in[s]  = div_step(long_in[s],  Q_W - 1 - s*BITS_STAGE - k);
            short_in[s] = div_step(short_in[s], Q_W - 1 - s*BITS_STAGE - k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) valid_ff[s] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < DIV_STAGES; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0] <= in_meta;
         for (int s = 1; s < DIV_STAGES; s++) meta_ff[s] <= meta_ff[s-1];
         for (int s = 0; s < DIV_STAGES; s++) begin
            long_ff[s]  <= long_in[s];
            short_ff[s] <= short_in[s];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_meta  = meta_ff[DIV_STAGES-1];
   assign out_long  = long_ff[DIV_STAGES-1];
   assign out_short = short_ff[DIV_STAGES-1];

endmodule

// File: hw/rtl/triangle_scanline_span_generator.sv
// ----------------------------------------------------------------------------
// triangle_scanline_span_generator
// Per-row horizontal span of a configured triangle, clipped to the screen.
//
//   port group | dir | handshake         | content
//   req_*      | in  | req_valid/ready   | row
//   rsp_*      | out | rsp_valid/ready   | span_valid, row_out, x_left, x_right, color
//   csr_*      | in  | csr_wr_en         | index, wdata
//
// One row per clock while rsp_ready does not stall the output; 3 setup stages, 8 divider
// stages of 2 quotient bits each (set by the 16-bit quotient), 1 output stage.
// Reset clears all valid bits and the configuration registers; no memory, no clearing pass.
// The whole pipeline holds while a result waits on rsp_ready; req_ready drops
// only then, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_scanline_span_generator #(
   parameter int SCREEN_WIDTH  = tssg_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tssg_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tssg_pkg::ROW_W-1:0]     req_row,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_span_valid,
   output logic [tssg_pkg::ROW_W-1:0]     rsp_row_out,
   output logic [tssg_pkg::X_W-1:0]       rsp_x_left,
   output logic [tssg_pkg::X_W-1:0]       rsp_x_right,
   output logic [tssg_pkg::COLOR_W-1:0]   rsp_span_color,
   input  logic                           csr_wr_en,
   input  logic [tssg_pkg::IDX_W-1:0]     csr_index,
   input  logic [tssg_pkg::CSR_W-1:0]     csr_wdata
);
   import tssg_pkg::*;

   logic [CRD_W-1:0]   crd_ff [6];
   logic [COLOR_W-1:0] color_ff;
   logic               adv;

   logic     su_valid, dv_valid;
   meta_type su_meta, dv_meta;
   lane_type su_long, su_short, dv_long, dv_short;

   logic signed [XS_W-1:0] xl, xs, xa, xb;
   logic                   ok;

   logic               rsp_valid_ff, span_valid_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [X_W-1:0]     x_left_ff, x_right_ff;
   logic [COLOR_W-1:0] color_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) crd_ff[i] <= '0;
         color_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_V0_X, CSR_V0_Y, CSR_V1_X, CSR_V1_Y, CSR_V2_X, CSR_V2_Y: begin
               crd_ff[csr_index] <= csr_wdata[CRD_W-1:0];
            end
            CSR_COLOR: begin
               color_ff <= csr_wdata[COLOR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   tssg_setup #(
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_setup (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .row       (req_row),
      .v0        ('{x: crd_ff[CSR_V0_X], y: crd_ff[CSR_V0_Y]}),
      .v1        ('{x: crd_ff[CSR_V1_X], y: crd_ff[CSR_V1_Y]}),
      .v2        ('{x: crd_ff[CSR_V2_X], y: crd_ff[CSR_V2_Y]}),
      .out_valid (su_valid),
      .out_meta  (su_meta),
      .out_long  (su_long),
      .out_short (su_short)
   );

   tssg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (su_valid),
      .in_meta   (su_meta),
      .in_long   (su_long),
      .in_short  (su_short),
      .out_valid (dv_valid),
      .out_meta  (dv_meta),
      .out_long  (dv_long),
      .out_short (dv_short)
   );

   function automatic logic signed [XS_W-1:0] edge_x(lane_type l);
      logic signed [XS_W-1:0] a;
      logic signed [XS_W-1:0] q;
      a = XS_W'($signed(l.ax));
      q = $signed({{(XS_W-Q_W){1'b0}}, l.quo});
      if (l.flat) return XS_W'($signed(l.bx));
      return l.neg ? a - q : a + q;
   endfunction

   always_comb begin
      xl = edge_x(dv_long);
      xs = edge_x(dv_short);
      xa = (xl < xs) ? xl : xs;
      xb = (xl < xs) ? xs : xl;
      ok = dv_meta.in_tri && !(xb < 0) && !(xa > XS_W'(SCREEN_WIDTH - 1));
      if (xa < 0) xa = '0;
      if (xb > XS_W'(SCREEN_WIDTH - 1)) xb = XS_W'(SCREEN_WIDTH - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         span_valid_ff <= ok;
         row_ff        <= dv_meta.row;
         x_left_ff     <= ok ? xa[X_W-1:0] : '0;
         x_right_ff    <= ok ? xb[X_W-1:0] : '0;
         color_out_ff  <= ok ? color_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span_valid = span_valid_ff;
   assign rsp_row_out    = row_ff;
   assign rsp_x_left     = x_left_ff;
   assign rsp_x_right    = x_right_ff;
   assign rsp_span_color = color_out_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output stall");
   a_empty_span: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_span_valid) |->
      (rsp_x_left == '0 && rsp_x_right == '0 && rsp_span_color == '0))
      else $error("invalid span carries data");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_x_left) && $stable(rsp_row_out)))
      else $error("result changed while stalled");

endmodule
